// ----- rtl/core/cau_pkg.sv -----
package cau_pkg;

   // Word format of the operands and results.
   localparam int WORD_BITS = 32;
   localparam int FRAC_BITS = 16;

   // Derived widths of the datapath.
   localparam int PROD_W = 2 * WORD_BITS;
   localparam int SUM_W  = PROD_W + 1;
   localparam int SAT_W  = SUM_W + 1;
   localparam int MAG_W  = PROD_W;
   localparam int DEN_W  = PROD_W;
   localparam int DVD_W  = MAG_W + FRAC_BITS;
   localparam int QUO_W  = WORD_BITS + 1;
   localparam int CMP_W  = DEN_W + QUO_W;
   localparam int IDX_W  = $clog2(QUO_W);

   // Saturation limits, sign-extended to the wide format.
   localparam logic signed [SAT_W-1:0] SAT_HI =
      {{(SAT_W-WORD_BITS+1){1'b0}}, {(WORD_BITS-1){1'b1}}};
   localparam logic signed [SAT_W-1:0] SAT_LO =
      {{(SAT_W-WORD_BITS+1){1'b1}}, {(WORD_BITS-1){1'b0}}};

   typedef enum logic [1:0] {
      OP_ADD = 2'd0,
      OP_SUB = 2'd1,
      OP_MUL = 2'd2,
      OP_DIV = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK  = 2'd0,
      ST_SAT = 2'd1,
      ST_DZ  = 2'd2
   } status_type;

   typedef struct packed {
      logic [WORD_BITS-1:0] val;
      logic                 sat;
   } sat_type;

   // Product stage contents.
   typedef struct packed {
      op_type                       op;
      logic                         dz;
      logic signed [WORD_BITS-1:0]  a_re;
      logic signed [WORD_BITS-1:0]  a_im;
      logic signed [WORD_BITS-1:0]  b_re;
      logic signed [WORD_BITS-1:0]  b_im;
      logic signed [PROD_W-1:0]     p_rr;
      logic signed [PROD_W-1:0]     p_ii;
      logic signed [PROD_W-1:0]     p_ri;
      logic signed [PROD_W-1:0]     p_ir;
      logic signed [PROD_W-1:0]     s_rr;
      logic signed [PROD_W-1:0]     s_ii;
   } prod_type;

   // Combine stage contents.
   typedef struct packed {
      op_type                   op;
      logic                     dz;
      logic [WORD_BITS-1:0]     re;
      logic [WORD_BITS-1:0]     im;
      logic                     sat;
      logic signed [SUM_W-1:0]  num_re;
      logic signed [SUM_W-1:0]  num_im;
      logic [DEN_W-1:0]         den;
   } comb_type;

   // Item that travels down the divider cells.
   typedef struct packed {
      op_type               op;
      logic                 dz;
      logic [WORD_BITS-1:0] re;
      logic [WORD_BITS-1:0] im;
      logic                 sat;
      logic [DEN_W-1:0]     den;
      logic                 neg_re;
      logic                 neg_im;
      logic                 ovf_re;
      logic                 ovf_im;
      logic [DVD_W-1:0]     rem_re;
      logic [DVD_W-1:0]     rem_im;
      logic [QUO_W-1:0]     quo_re;
      logic [QUO_W-1:0]     quo_im;
   } cau_item_type;

   // Clamp a wide signed value to the word range.
   function automatic sat_type saturate(input logic signed [SAT_W-1:0] v);
      sat_type r;
      if (v > SAT_HI) begin
         r.val = SAT_HI[WORD_BITS-1:0];
         r.sat = 1'b1;
      end else if (v < SAT_LO) begin
         r.val = SAT_LO[WORD_BITS-1:0];
         r.sat = 1'b1;
      end else begin
         r.val = v[WORD_BITS-1:0];
         r.sat = 1'b0;
      end
      return r;
   endfunction

endpackage

// ----- rtl/core/cau_if.sv -----
interface cau_req_if;
   import cau_pkg::*;
   logic                        valid;
   logic                        ready;
   logic [1:0]                  func;
   logic signed [WORD_BITS-1:0] a_re;
   logic signed [WORD_BITS-1:0] a_im;
   logic signed [WORD_BITS-1:0] b_re;
   logic signed [WORD_BITS-1:0] b_im;

   modport source (output valid, func, a_re, a_im, b_re, b_im, input ready);
   modport sink (input valid, func, a_re, a_im, b_re, b_im, output ready);
endinterface

interface cau_rsp_if;
   import cau_pkg::*;
   logic                        valid;
   logic                        ready;
   logic signed [WORD_BITS-1:0] res_re;
   logic signed [WORD_BITS-1:0] res_im;
   logic [1:0]                  status;

   modport source (output valid, res_re, res_im, status, input ready);
   modport sink (input valid, res_re, res_im, status, output ready);
endinterface

// ----- rtl/core/cau_front.sv -----
module cau_front (
   input  logic                  clock,
   input  logic                  reset,
   cau_req_if.sink               req,
   output logic                  dn_valid,
   input  logic                  dn_ready,
   output cau_pkg::cau_item_type dn_item
);
   import cau_pkg::*;

   logic         s1_valid_ff, s2_valid_ff, s3_valid_ff;
   logic         s1_ready, s2_ready, s3_ready;
   prod_type     s1_ff, s1_in;
   comb_type     s2_ff, s2_in;
   cau_item_type s3_ff, s3_in;

   logic signed [SUM_W-1:0] mul_re, mul_im;
   logic signed [SUM_W-1:0] sh_re, sh_im;
   logic signed [SAT_W-1:0] add_re, add_im;
   logic [MAG_W-1:0]        mag_re, mag_im;
   sat_type                 fix_re, fix_im;

   // Each stage takes a new beat when it is empty or its content moves on.
   assign s3_ready  = !s3_valid_ff || dn_ready;
   assign s2_ready  = !s2_valid_ff || s3_ready;
   assign s1_ready  = !s1_valid_ff || s2_ready;
   assign req.ready = s1_ready;
   assign dn_valid  = s3_valid_ff;
   assign dn_item   = s3_ff;

   // Stage one: all six products of the operand parts.
   always_comb begin
      s1_in.op   = op_type'(req.func);
      s1_in.dz   = (req.b_re == '0) && (req.b_im == '0);
      s1_in.a_re = req.a_re;
      s1_in.a_im = req.a_im;
      s1_in.b_re = req.b_re;
      s1_in.b_im = req.b_im;
      s1_in.p_rr = PROD_W'(req.a_re) * PROD_W'(req.b_re);
      s1_in.p_ii = PROD_W'(req.a_im) * PROD_W'(req.b_im);
      s1_in.p_ri = PROD_W'(req.a_re) * PROD_W'(req.b_im);
      s1_in.p_ir = PROD_W'(req.a_im) * PROD_W'(req.b_re);
      s1_in.s_rr = PROD_W'(req.b_re) * PROD_W'(req.b_re);
      s1_in.s_ii = PROD_W'(req.b_im) * PROD_W'(req.b_im);
   end

   // Stage two: sums, differences, scaled products and the divisor.
   always_comb begin
      if (s1_ff.op == OP_SUB) begin
         add_re = SAT_W'(s1_ff.a_re) - SAT_W'(s1_ff.b_re);
         add_im = SAT_W'(s1_ff.a_im) - SAT_W'(s1_ff.b_im);
      end else begin
         add_re = SAT_W'(s1_ff.a_re) + SAT_W'(s1_ff.b_re);
         add_im = SAT_W'(s1_ff.a_im) + SAT_W'(s1_ff.b_im);
      end
      mul_re = SUM_W'(s1_ff.p_rr) - SUM_W'(s1_ff.p_ii);
      mul_im = SUM_W'(s1_ff.p_ri) + SUM_W'(s1_ff.p_ir);
      sh_re  = mul_re >>> FRAC_BITS;
      sh_im  = mul_im >>> FRAC_BITS;
      if (s1_ff.op == OP_MUL) begin
         fix_re = saturate(SAT_W'(sh_re));
         fix_im = saturate(SAT_W'(sh_im));
      end else begin
         fix_re = saturate(add_re);
         fix_im = saturate(add_im);
      end
      s2_in.op     = s1_ff.op;
      s2_in.dz     = s1_ff.dz;
      s2_in.re     = fix_re.val;
      s2_in.im     = fix_im.val;
      s2_in.sat    = fix_re.sat || fix_im.sat;
      s2_in.num_re = SUM_W'(s1_ff.p_rr) + SUM_W'(s1_ff.p_ii);
      s2_in.num_im = SUM_W'(s1_ff.p_ir) - SUM_W'(s1_ff.p_ri);
      s2_in.den    = DEN_W'(s1_ff.s_rr) + DEN_W'(s1_ff.s_ii);
   end

   // Stage three: magnitudes, scaled dividends and the overflow test.
   always_comb begin
      mag_re = s2_ff.num_re[SUM_W-1] ? MAG_W'(-s2_ff.num_re) : MAG_W'(s2_ff.num_re);
      mag_im = s2_ff.num_im[SUM_W-1] ? MAG_W'(-s2_ff.num_im) : MAG_W'(s2_ff.num_im);
      s3_in.op     = s2_ff.op;
      s3_in.dz     = s2_ff.dz;
      s3_in.re     = s2_ff.re;
      s3_in.im     = s2_ff.im;
      s3_in.sat    = s2_ff.sat;
      s3_in.den    = s2_ff.den;
      s3_in.neg_re = s2_ff.num_re[SUM_W-1];
      s3_in.neg_im = s2_ff.num_im[SUM_W-1];
      s3_in.rem_re = {mag_re, {FRAC_BITS{1'b0}}};
      s3_in.rem_im = {mag_im, {FRAC_BITS{1'b0}}};
      s3_in.ovf_re = CMP_W'(s3_in.rem_re) >= (CMP_W'(s2_ff.den) << QUO_W);
      s3_in.ovf_im = CMP_W'(s3_in.rem_im) >= (CMP_W'(s2_ff.den) << QUO_W);
      s3_in.quo_re = '0;
      s3_in.quo_im = '0;
   end

   // Stage valid flags.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         if (s1_ready) begin
            s1_valid_ff <= req.valid;
         end
         if (s2_ready) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (s3_ready) begin
            s3_valid_ff <= s2_valid_ff;
         end
      end
   end

   // Stage payloads.
   always_ff @(posedge clock) begin
      if (s1_ready && req.valid) begin
         s1_ff <= s1_in;
      end
      if (s2_ready && s1_valid_ff) begin
         s2_ff <= s2_in;
      end
      if (s3_ready && s2_valid_ff) begin
         s3_ff <= s3_in;
      end
   end

endmodule

// ----- rtl/core/cau_cell.sv -----
module cau_cell (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [cau_pkg::IDX_W-1:0]     bit_idx,
   input  logic                          up_valid,
   output logic                          up_ready,
   input  cau_pkg::cau_item_type         up_item,
   output logic                          dn_valid,
   input  logic                          dn_ready,
   output cau_pkg::cau_item_type         dn_item
);
   import cau_pkg::*;

   logic             valid_ff;
   cau_item_type     item_ff, item_in;
   logic [CMP_W-1:0] trial;
   logic             take_re, take_im;

   assign up_ready = !valid_ff || dn_ready;
   assign dn_valid = valid_ff;
   assign dn_item  = item_ff;

   // One restoring step for both lanes: subtract the shifted divisor if it fits.
   always_comb begin
      item_in = up_item;
      trial   = CMP_W'(up_item.den) << bit_idx;
      take_re = !up_item.ovf_re && (CMP_W'(up_item.rem_re) >= trial);
      take_im = !up_item.ovf_im && (CMP_W'(up_item.rem_im) >= trial);
      if (take_re) begin
         item_in.rem_re          = up_item.rem_re - trial[DVD_W-1:0];
         item_in.quo_re[bit_idx] = 1'b1;
      end
      if (take_im) begin
         item_in.rem_im          = up_item.rem_im - trial[DVD_W-1:0];
         item_in.quo_im[bit_idx] = 1'b1;
      end
   end

   // Cell register.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && up_valid) begin
         item_ff <= item_in;
      end
   end

endmodule

// ----- rtl/core/complex_arithmetic_unit.sv -----
// A request beat passes through three front stages, 33 divider cells and one
// output register on its way to its response beat.
// Throughput: one beat per cycle for every operation, unless rsp.ready stalls
// it; the divider cells each resolve one quotient bit and pass the beat on.
// Reset clears all stage valid flags; no clearing pass, the unit is ready at once.
module complex_arithmetic_unit (
   input  logic     clock,
   input  logic     reset,
   cau_req_if.sink  req,
   cau_rsp_if.source rsp
);
   import cau_pkg::*;

   logic         cell_valid [QUO_W+1];
   logic         cell_ready [QUO_W+1];
   cau_item_type cell_item  [QUO_W+1];

   logic                 out_valid_ff, out_ready;
   logic [WORD_BITS-1:0] out_re_ff, out_im_ff, out_re_in, out_im_in;
   status_type           out_status_ff, out_status_in;
   cau_item_type         last;
   sat_type              fin_re, fin_im;

   // Signed, saturated quotient of one lane.
   function automatic sat_type div_lane(input logic neg, input logic ovf,
                                        input logic [QUO_W-1:0] quo);
      logic signed [SAT_W-1:0] q;
      sat_type r;
      q = $signed({{(SAT_W-QUO_W){1'b0}}, quo});
      if (ovf) begin
         r.val = neg ? SAT_LO[WORD_BITS-1:0] : SAT_HI[WORD_BITS-1:0];
         r.sat = 1'b1;
      end else begin
         r = saturate(neg ? -q : q);
      end
      return r;
   endfunction

   cau_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req      (req),
      .dn_valid (cell_valid[0]),
      .dn_ready (cell_ready[0]),
      .dn_item  (cell_item[0])
   );

   // Divider chain, most significant quotient bit first.
   for (genvar k = 0; k < QUO_W; k++) begin : g_cell
      cau_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .bit_idx  (IDX_W'(QUO_W - 1 - k)),
         .up_valid (cell_valid[k]),
         .up_ready (cell_ready[k]),
         .up_item  (cell_item[k]),
         .dn_valid (cell_valid[k+1]),
         .dn_ready (cell_ready[k+1]),
         .dn_item  (cell_item[k+1])
      );
   end

   assign last              = cell_item[QUO_W];
   assign out_ready         = !out_valid_ff || rsp.ready;
   assign cell_ready[QUO_W] = out_ready;

   // Final result selection and status.
   always_comb begin
      fin_re = div_lane(last.neg_re, last.ovf_re, last.quo_re);
      fin_im = div_lane(last.neg_im, last.ovf_im, last.quo_im);
      if (last.op == OP_DIV) begin
         if (last.dz) begin
            out_re_in     = '0;
            out_im_in     = '0;
            out_status_in = ST_DZ;
         end else begin
            out_re_in     = fin_re.val;
            out_im_in     = fin_im.val;
            out_status_in = (fin_re.sat || fin_im.sat) ? ST_SAT : ST_OK;
         end
      end else begin
         out_re_in     = last.re;
         out_im_in     = last.im;
         out_status_in = last.sat ? ST_SAT : ST_OK;
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_ready) begin
         out_valid_ff <= cell_valid[QUO_W];
      end
   end

   always_ff @(posedge clock) begin
      if (out_ready && cell_valid[QUO_W]) begin
         out_re_ff     <= out_re_in;
         out_im_ff     <= out_im_in;
         out_status_ff <= out_status_in;
      end
   end

   assign rsp.valid  = out_valid_ff;
   assign rsp.res_re = out_re_ff;
   assign rsp.res_im = out_im_ff;
   assign rsp.status = out_status_ff;

   // A division by zero delivers zero parts.
   a_dz_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.status == ST_DZ) |-> (rsp.res_re == '0 && rsp.res_im == '0))
      else $error("division by zero response carries nonzero parts");

   // Nothing leaves the unit in the first cycle after reset is released.
   a_reset_empty: assert property (@(posedge clock)
      ($past(reset) && !reset) |-> !rsp.valid)
      else $error("response valid right after reset");

   // The request side stalls only when the response side is stalled.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req.ready |-> (rsp.valid && !rsp.ready))
      else $error("request stalled while response side is free");

endmodule
